/* rtl/core/loc_pkg.sv */
// Shared types and codes of the latch order checker.
`timescale 1ns / 1ps

package loc_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_CHECK   = 2'd0;
    localparam logic [1:0] ACT_ACQUIRE = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_RSVD    = 2'd3;

    // Latch class codes; the upper bit set means exempt
    localparam logic [1:0] CLS_RANKED   = 2'd0;
    localparam logic [1:0] CLS_UNRANKED = 2'd1;
    localparam logic [1:0] CLS_EXEMPT   = 2'd2;
    // reserved class, handled as exempt
    localparam logic [1:0] CLS_RSVD     = 2'd3;

    typedef enum logic [2:0] {
        OC_OK       = 3'd0,
        OC_SELF     = 3'd1,
        OC_INV      = 3'd2,
        OC_REPEAT   = 3'd3,
        OC_IGNORED  = 3'd4,
        OC_OVERFLOW = 3'd5,
        OC_NOTFOUND = 3'd6
    } t_outcome;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_START,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    // One held latch in the table
    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  rank;
        logic        unranked;
    } t_entry;

    // One input word
    typedef struct packed {
        logic [1:0]  action;
        logic        latch_valid;
        logic [31:0] latch_id;
        logic [1:0]  latch_class;
        logic [3:0]  latch_rank;
    } t_item;

    // One result word
    typedef struct packed {
        t_outcome    outcome;
        logic [3:0]  conflict_slot;
        logic [31:0] conflict_latch_id;
        logic [3:0]  conflict_rank;
        logic        overflow_warning;
        logic [4:0]  held_count;
        logic        halted;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        t_idx_op  idx_op;
        logic     rd_ahead;
        logic     push;
        logic     shift_wr;
        logic     pop;
        logic     set_ovf;
        logic     report;
        logic     out_load;
        t_outcome outcome;
        logic     conf;
        logic     warn;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       ignore;
        logic [1:0] action;
        logic       exempt;
        logic       depth_zero;
        logic       full;
        logic       id_match;
        logic       rank_hit;
        logic       idx_last;
        logic       idx_zero;
        logic       shift_last;
        logic       ovf_seen;
    } t_dp_sts;

endpackage

/* rtl/core/loc_dp.sv */
// Datapath: held-latch table, scan index, report state and result register.
`timescale 1ns / 1ps

module loc_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  loc_pkg::t_item   i_item,
    input  loc_pkg::t_dp_cmd i_cmd,
    output loc_pkg::t_dp_sts o_sts,
    output loc_pkg::t_result o_result
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    loc_pkg::t_entry  r_table [STACK_DEPTH];
    loc_pkg::t_entry  r_rd_entry;
    loc_pkg::t_entry  wr_data;
    loc_pkg::t_item   r_item;
    loc_pkg::t_result r_result;
    loc_pkg::t_outcome out_code;

    logic [SW-1:0] r_idx, n_idx, rd_addr, wr_addr;
    logic [CW-1:0] r_depth, n_depth, idx_ext, depth_m1;
    logic [SW+3:0] slot_ext;
    logic [CW+4:0] cnt_ext;
    logic          wr_en;
    logic          item_unranked;
    logic          pair_eq;
    logic          r_ovf_seen, r_stopped, n_stopped, r_warn_only;
    logic [31:0]   r_last_held, r_last_new;

    assign idx_ext       = CW'(r_idx);
    assign depth_m1      = r_depth - CW'(1);
    assign item_unranked = (r_item.latch_class == loc_pkg::CLS_UNRANKED);
    assign pair_eq       = (r_last_held == r_rd_entry.id) && (r_last_new == r_item.latch_id);

    // Next scan index
    always_comb begin
        case (i_cmd.idx_op)
            loc_pkg::IDX_START: begin
                if (i_item.action == loc_pkg::ACT_RELEASE && r_depth != '0) begin
                    n_idx = depth_m1[SW-1:0];
                end else begin
                    n_idx = '0;
                end
            end
            loc_pkg::IDX_INC: n_idx = r_idx + 1'b1;
            loc_pkg::IDX_DEC: n_idx = r_idx - 1'b1;
            default:          n_idx = r_idx;
        endcase
    end

    // Read the entry under the index, or the one above it while closing a gap
    assign rd_addr = i_cmd.rd_ahead ? n_idx + 1'b1 : n_idx;

    // Push at the top, or move an entry down one slot
    always_comb begin
        wr_en = i_cmd.push | i_cmd.shift_wr;
        if (i_cmd.push) begin
            wr_addr          = r_depth[SW-1:0];
            wr_data.id       = r_item.latch_id;
            wr_data.rank     = item_unranked ? 4'd0 : r_item.latch_rank;
            wr_data.unranked = item_unranked;
        end else begin
            wr_addr = r_idx;
            wr_data = r_rd_entry;
        end
    end

    // Table storage with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        r_rd_entry <= r_table[rd_addr];
    end

    // Depth, stop and outcome after this step
    always_comb begin
        if (i_cmd.push) begin
            n_depth = r_depth + CW'(1);
        end else if (i_cmd.pop) begin
            n_depth = depth_m1;
        end else begin
            n_depth = r_depth;
        end
        n_stopped = r_stopped | (i_cmd.report & ~r_warn_only);
        if (i_cmd.report && r_warn_only && pair_eq) begin
            out_code = loc_pkg::OC_REPEAT;
        end else begin
            out_code = i_cmd.outcome;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_ovf_seen  <= 1'b0;
            r_stopped   <= 1'b0;
            r_last_held <= '0;
            r_last_new  <= '0;
            r_warn_only <= 1'b0;
        end else begin
            r_depth   <= n_depth;
            r_stopped <= n_stopped;
            if (i_cmd.set_ovf) begin
                r_ovf_seen <= 1'b1;
            end
            if (i_cmd.report && r_warn_only && !pair_eq) begin
                r_last_held <= r_rd_entry.id;
                r_last_new  <= r_item.latch_id;
            end
            if (i_cfg_we) begin
                r_warn_only <= i_cfg_wdata;
            end
        end
    end

    assign slot_ext = {4'b0, r_idx};
    assign cnt_ext  = {5'b0, n_depth};

    // Item, index and result word
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.out_load) begin
            r_result.outcome           <= out_code;
            r_result.conflict_slot     <= i_cmd.conf ? slot_ext[3:0] : 4'd0;
            r_result.conflict_latch_id <= i_cmd.conf ? r_rd_entry.id : 32'd0;
            r_result.conflict_rank     <= i_cmd.conf ? r_rd_entry.rank : 4'd0;
            r_result.overflow_warning  <= i_cmd.warn;
            r_result.held_count        <= cnt_ext[4:0];
            r_result.halted            <= n_stopped;
        end
    end

    assign o_result = r_result;

    // Status toward the controller
    always_comb begin
        o_sts.ignore     = ~r_item.latch_valid | r_stopped
                         | (r_item.action == loc_pkg::ACT_RSVD);
        o_sts.action     = r_item.action;
        o_sts.exempt     = r_item.latch_class[1];
        o_sts.depth_zero = (r_depth == '0);
        o_sts.full       = (r_depth == CW'(STACK_DEPTH));
        o_sts.id_match   = (r_rd_entry.id == r_item.latch_id);
        o_sts.rank_hit   = ~item_unranked & ~r_rd_entry.unranked
                         & (r_rd_entry.rank > r_item.latch_rank);
        o_sts.idx_last   = (idx_ext == depth_m1);
        o_sts.idx_zero   = (r_idx == '0);
        o_sts.shift_last = ((idx_ext + CW'(2)) == r_depth);
        o_sts.ovf_seen   = r_ovf_seen;
    end

endmodule

/* rtl/core/loc_ctrl.sv */
// Controller: sequences scan, push and gap closing, and owns the result valid.
`timescale 1ns / 1ps

module loc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output loc_pkg::t_dp_cmd o_cmd,
    input  loc_pkg::t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Commands and next state
    always_comb begin
        o_cmd         = '0;
        o_cmd.idx_op  = loc_pkg::IDX_HOLD;
        o_cmd.outcome = loc_pkg::OC_OK;
        n_state       = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.idx_op    = loc_pkg::IDX_START;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // hold the current entry until the result register is free
                if (out_free) begin
                    if (i_sts.ignore) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.outcome  = loc_pkg::OC_IGNORED;
                    end else begin
                        case (i_sts.action)
                            loc_pkg::ACT_CHECK: begin
                                if (i_sts.exempt || i_sts.depth_zero) begin
                                    o_cmd.out_load = 1'b1;
                                end else if (i_sts.id_match) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.report   = 1'b1;
                                    o_cmd.conf     = 1'b1;
                                    o_cmd.outcome  = loc_pkg::OC_SELF;
                                end else if (i_sts.rank_hit) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.report   = 1'b1;
                                    o_cmd.conf     = 1'b1;
                                    o_cmd.outcome  = loc_pkg::OC_INV;
                                end else if (i_sts.idx_last) begin
                                    o_cmd.out_load = 1'b1;
                                end else begin
                                    o_cmd.idx_op = loc_pkg::IDX_INC;
                                end
                            end
                            loc_pkg::ACT_ACQUIRE: begin
                                o_cmd.out_load = 1'b1;
                                if (i_sts.exempt) begin
                                    o_cmd.outcome = loc_pkg::OC_OK;
                                end else if (i_sts.full) begin
                                    o_cmd.outcome = loc_pkg::OC_OVERFLOW;
                                    o_cmd.warn    = ~i_sts.ovf_seen;
                                    o_cmd.set_ovf = 1'b1;
                                end else begin
                                    o_cmd.push = 1'b1;
                                end
                            end
                            loc_pkg::ACT_RELEASE: begin
                                if (i_sts.depth_zero) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.outcome  = loc_pkg::OC_NOTFOUND;
                                end else if (i_sts.id_match) begin
                                    if (i_sts.idx_last) begin
                                        o_cmd.out_load = 1'b1;
                                        o_cmd.pop      = 1'b1;
                                    end else begin
                                        o_cmd.rd_ahead = 1'b1;
                                        n_state        = ST_SHIFT;
                                    end
                                end else if (i_sts.idx_zero) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.outcome  = loc_pkg::OC_NOTFOUND;
                                end else begin
                                    o_cmd.idx_op = loc_pkg::IDX_DEC;
                                end
                            end
                            default: begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.outcome  = loc_pkg::OC_IGNORED;
                            end
                        endcase
                    end
                    if (o_cmd.out_load) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SHIFT: begin
                // keep the entry above the gap in the read register
                o_cmd.rd_ahead = 1'b1;
                if (out_free) begin
                    o_cmd.shift_wr = 1'b1;
                    if (i_sts.shift_last) begin
                        o_cmd.pop      = 1'b1;
                        o_cmd.out_load = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        o_cmd.idx_op = loc_pkg::IDX_INC;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/latch_order_checker_core.sv */
// Top level of the latch order checker: controller, datapath and port wiring.
//
// Input channel: i_in_valid / o_in_stall carry one request word (check,
// acquire or release of a latch). Output channel: o_out_valid / i_out_stall
// carry exactly one result word per request, in request order. A word moves
// at a rising edge with valid high and stall low.
// Configuration: i_cfg_we writes i_cfg_wdata into the warn-only bit; write
// it only while no request is in flight.
// Timing: one word at a time. After accept, a request visits table entries
// one by one through the single registered table read port: acquire and
// ignored words visit none, a check scans up from the bottom entry, and a
// release scans down from the top entry and then moves each entry above the
// match down one slot to close the gap.
// o_in_stall is high from accept until the result is in the output register,
// so the next request is taken while that result still waits.
// Reset empties the table, clears the overflow, halt and last-pair state and
// selects fatal mode; table contents need no clearing pass.
// While the receiver stalls a waiting result, the block finishes no further
// request and holds its scan in place.
`timescale 1ns / 1ps

module latch_order_checker_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic        i_latch_valid,
    input  logic [31:0] i_latch_id,
    input  logic [1:0]  i_latch_class,
    input  logic [3:0]  i_latch_rank,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_outcome,
    output logic [3:0]  o_conflict_slot,
    output logic [31:0] o_conflict_latch_id,
    output logic [3:0]  o_conflict_rank,
    output logic        o_overflow_warning,
    output logic [4:0]  o_held_count,
    output logic        o_halted
);

    loc_pkg::t_item   item;
    loc_pkg::t_dp_cmd cmd;
    loc_pkg::t_dp_sts sts;
    loc_pkg::t_result result;

    // Gather the request word
    always_comb begin
        item.action      = i_action;
        item.latch_valid = i_latch_valid;
        item.latch_id    = i_latch_id;
        item.latch_class = i_latch_class;
        item.latch_rank  = i_latch_rank;
    end

    loc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    loc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (result)
    );

    // Split the result word onto the ports
    assign o_outcome           = result.outcome;
    assign o_conflict_slot     = result.conflict_slot;
    assign o_conflict_latch_id = result.conflict_latch_id;
    assign o_conflict_rank     = result.conflict_rank;
    assign o_overflow_warning  = result.overflow_warning;
    assign o_held_count        = result.held_count;
    assign o_halted            = result.halted;

endmodule
